@@ rtl/core/chlaf_pkg.sv @@
// Shared types and constants for the cascaded high-pass / low-pass audio filter.
// Holds the sequencer state type, filter coefficients and sample limits.
// No dependencies.
package chlaf_pkg;

  // Sample and internal widths
  localparam int SAMPLE_W = 16;
  localparam int HP_W     = 24;   // high-pass stage history
  localparam int LP_W     = 17;   // low-pass stage history
  localparam int OPND_W   = 26;   // multiplier data operand
  localparam int COEF_W   = 18;   // multiplier coefficient operand
  localparam int PROD_W   = OPND_W + COEF_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int FRAC_W   = 16;   // Q16 coefficients

  // Coefficients (Q16)
  localparam logic signed [COEF_W-1:0] HP_COEFF     = 18'sd40960;
  localparam logic signed [COEF_W-1:0] LP_NEW_COEFF = 18'sd61439;  // 65535 - 4096
  localparam int                       LP_KEEP_SHL  = 12;          // y_prev * 4096

  // Saturation limits
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = 16'sh8000;

  // Sequencer states: each filter stage is one step on the shared multiplier
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HP1,
    ST_HP2,
    ST_HP3,
    ST_AMP,
    ST_LP1,
    ST_LP2,
    ST_LP3,
    ST_FIN
  } state_t;

endpackage

@@ rtl/core/cascaded_highpass_lowpass_audio_filter.sv @@
// Each accepted sample steps through HP1, HP2, HP3, AMP, LP1, LP2, LP3 and FIN;
// FIN loads the output register, waiting while it still holds an unread sample.
// The single shared multiplier runs the three high-pass and three low-pass stages
// one after another, one stage a cycle. in_ready is high only in the idle state; a
// finished sample may wait in the output register while the next sample is taken in.
// Reset (rst_n, synchronous, active low) clears all filter history and the sequencer.
module cascaded_highpass_lowpass_audio_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [chlaf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [chlaf_pkg::SAMPLE_W-1:0] out_sample_out
);
  import chlaf_pkg::*;

  // Sequencer
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_out;
  logic   in_xfer, out_xfer;

  // Filter history
  logic signed [SAMPLE_W-1:0] hp_in_r;
  logic signed [HP_W-1:0]     h1_r, h2_r, h3_r;
  logic signed [LP_W-1:0]     l1_r, l2_r, l3_r;

  // Working registers
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [HP_W-1:0]     prev_r;      // previous output of the stage just updated
  logic signed [SAMPLE_W-1:0] amp_r;
  logic signed [SAMPLE_W-1:0] out_r;

  // Shared multiply-accumulate unit
  logic signed [OPND_W-1:0] op_x, op_xp, op_yp, mult_a;
  logic signed [COEF_W-1:0] mult_c;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  addend, acc;
  logic                     is_lp;
  logic signed [HP_W-1:0]   hp_res;
  logic signed [LP_W-1:0]   lp_res;
  logic signed [SAMPLE_W-1:0] amp_sat, fin_sat;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_HP1;
      ST_HP1:  state_nxt = ST_HP2;
      ST_HP2:  state_nxt = ST_HP3;
      ST_HP3:  state_nxt = ST_AMP;
      ST_AMP:  state_nxt = ST_LP1;
      ST_LP1:  state_nxt = ST_LP2;
      ST_LP2:  state_nxt = ST_LP3;
      ST_LP3:  state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_FIN:  load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_xfer) out_valid_nxt = 1'b0;
  end

  // Operand selection for the stage in progress
  always_comb begin
    op_x  = '0;
    op_xp = '0;
    op_yp = '0;
    is_lp = 1'b0;
    case (state_r)
      ST_HP1: begin
        op_x  = {{(OPND_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
        op_xp = {{(OPND_W-SAMPLE_W){hp_in_r[SAMPLE_W-1]}}, hp_in_r};
        op_yp = {{(OPND_W-HP_W){h1_r[HP_W-1]}}, h1_r};
      end
      ST_HP2: begin
        op_x  = {{(OPND_W-HP_W){h1_r[HP_W-1]}}, h1_r};
        op_xp = {{(OPND_W-HP_W){prev_r[HP_W-1]}}, prev_r};
        op_yp = {{(OPND_W-HP_W){h2_r[HP_W-1]}}, h2_r};
      end
      ST_HP3: begin
        op_x  = {{(OPND_W-HP_W){h2_r[HP_W-1]}}, h2_r};
        op_xp = {{(OPND_W-HP_W){prev_r[HP_W-1]}}, prev_r};
        op_yp = {{(OPND_W-HP_W){h3_r[HP_W-1]}}, h3_r};
      end
      ST_LP1: begin
        is_lp = 1'b1;
        op_x  = {{(OPND_W-SAMPLE_W){amp_r[SAMPLE_W-1]}}, amp_r};
        op_yp = {{(OPND_W-LP_W){l1_r[LP_W-1]}}, l1_r};
      end
      ST_LP2: begin
        is_lp = 1'b1;
        op_x  = {{(OPND_W-LP_W){l1_r[LP_W-1]}}, l1_r};
        op_yp = {{(OPND_W-LP_W){l2_r[LP_W-1]}}, l2_r};
      end
      ST_LP3: begin
        is_lp = 1'b1;
        op_x  = {{(OPND_W-LP_W){l2_r[LP_W-1]}}, l2_r};
        op_yp = {{(OPND_W-LP_W){l3_r[LP_W-1]}}, l3_r};
      end
      default: begin
        op_x  = '0;
        op_xp = '0;
        op_yp = '0;
        is_lp = 1'b0;
      end
    endcase
  end

  // Multiply-accumulate: high-pass uses (x + y_prev - x_prev) * 40960,
  // low-pass uses x * 61439 + y_prev * 4096; floor shift by 16 is a bit-select
  always_comb begin
    mult_a = is_lp ? op_x : (op_x + op_yp - op_xp);
    mult_c = is_lp ? LP_NEW_COEFF : HP_COEFF;
    addend = is_lp ? ({{(ACC_W-OPND_W){op_yp[OPND_W-1]}}, op_yp} <<< LP_KEEP_SHL) : '0;
    prod   = mult_a * mult_c;
    acc    = {prod[PROD_W-1], prod} + addend;
    hp_res = acc[FRAC_W+HP_W-1:FRAC_W];
    lp_res = acc[FRAC_W+LP_W-1:FRAC_W];
  end

  // Gain of 4 after the high-pass chain, gain of 2 after the low-pass chain
  always_comb begin
    if (h3_r > 24'sd8191)
      amp_sat = S16_MAX;
    else if (h3_r < -24'sd8192)
      amp_sat = S16_MIN;
    else
      amp_sat = {h3_r[SAMPLE_W-3:0], 2'b00};

    if (l3_r > 17'sd16383)
      fin_sat = S16_MAX;
    else if (l3_r < -17'sd16384)
      fin_sat = S16_MIN;
    else
      fin_sat = {l3_r[SAMPLE_W-2:0], 1'b0};
  end

  // Control and filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hp_in_r     <= '0;
      h1_r        <= '0;
      h2_r        <= '0;
      h3_r        <= '0;
      l1_r        <= '0;
      l2_r        <= '0;
      l3_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_HP1: begin
          hp_in_r <= x_r;
          h1_r    <= hp_res;
        end
        ST_HP2:  h2_r <= hp_res;
        ST_HP3:  h3_r <= hp_res;
        ST_LP1:  l1_r <= lp_res;
        ST_LP2:  l2_r <= lp_res;
        ST_LP3:  l3_r <= lp_res;
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) x_r <= in_sample_in;
    if (state_r == ST_HP1) prev_r <= h1_r;
    if (state_r == ST_HP2) prev_r <= h2_r;
    if (state_r == ST_AMP) amp_r <= amp_sat;
    if (load_out) out_r <= fin_sat;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_HP1)
    else $error("accepted sample did not start the high-pass chain");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished sample not loaded into output register");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("output valid raised outside the final step");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HP1) |-> ##7 (state_r == ST_FIN && !in_ready))
    else $error("sequencer step count broken");

endmodule
